@@ src/qenc_pkg.sv @@
// ----------------------------------------------------------------------------
// qenc_pkg
// Shared types, constants and the quadrature transition decode for the
// encoder-to-MIDI control-change block.
// ----------------------------------------------------------------------------
package qenc_pkg;

	// default geometry
	localparam int ENCODERS_PER_GROUP_DEF = 8;
	localparam int GROUPS_DEF             = 2;

	// widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int ENC_IDX_W  = 6;   // global encoder number, up to 64 encoders

	// event constants
	localparam logic [7:0] USB_HDR_CC = 8'h0B;
	localparam logic [7:0] STATUS_CC  = 8'hB0;
	localparam logic [6:0] DATA_UP    = 7'h01;
	localparam logic [6:0] DATA_DOWN  = 7'd127;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIDI_CHANNEL,
		CFG_ABSOLUTE_MODE,
		CFG_STEP_SIZE,
		CFG_MAX_VALUE,
		CFG_ENCODER_COUNT,
		CFG_CONTROLLERS_LOW,
		CFG_CONTROLLERS_HIGH
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MOVE_NONE,
		MOVE_UP,
		MOVE_DOWN
	} move_t;

	typedef struct packed {
		logic [3:0]  midi_channel;
		logic        absolute_mode;
		logic [6:0]  step_size;
		logic [6:0]  max_value;
		logic [4:0]  encoder_count;
		logic [63:0] controllers_low;
		logic [63:0] controllers_high;
	} cfg_t;

	typedef struct packed {
		logic       group_sel;
		logic [7:0] a_bits;
		logic [7:0] b_bits;
		logic       prime;
	} in_word_t;

	typedef struct packed {
		logic [7:0] usb_header;
		logic [7:0] status_byte;
		logic [7:0] controller;
		logic [6:0] data_value;
		logic       last;
	} out_word_t;

	// per-scan control handed to every lane
	typedef struct packed {
		logic load;       // word accepted for a group that exists
		logic prime;
		logic group_ok;
		logic group_sel;
	} lane_ctl_t;

	// code is {prev B, prev A, new B, new A}
	function automatic move_t move_of(input logic [3:0] code);
		move_t mv;
		case (code) inside
			4'h2, 4'hD: mv = MOVE_UP;
			4'h7, 4'h8: mv = MOVE_DOWN;
			default:    mv = MOVE_NONE;
		endcase
		return mv;
	endfunction

endpackage

@@ src/quadrature_encoders_to_midi_cc.sv @@
// ----------------------------------------------------------------------------
// quadrature_encoders_to_midi_cc
// Decodes scans of quadrature encoder groups into USB-MIDI control-change
// words, relative or absolute with clamping.
//
//   channel  | signals                               | moves
//   ---------+---------------------------------------+------------------------
//   in       | in_valid, in_ready, in_word           | one scan of a group
//   out      | out_valid, out_ready, out_word        | one control-change word
//   cfg      | cfg_we, cfg_index, cfg_data           | register write
//
// All lanes decode a scan in the cycle it is accepted; the merge stage then
// sends one word per cycle, one for each move (up to ENCODERS_PER_GROUP).
// A new scan is taken once the merge stage has handed its last word to the
// output register. Reset loads the register defaults and clears phases and
// positions. A stalled output holds the merge stage.
// ----------------------------------------------------------------------------
module quadrature_encoders_to_midi_cc import qenc_pkg::*; #(
	parameter int ENCODERS_PER_GROUP = ENCODERS_PER_GROUP_DEF,
	parameter int GROUPS             = GROUPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_word_t              in_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_word_t             out_word,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int EPG = ENCODERS_PER_GROUP;

	cfg_t           cfg_q;
	lane_ctl_t      ctl;
	logic           accept, busy;
	logic [EPG-1:0] evt;
	logic [6:0]     lane_data [EPG];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.midi_channel     <= 4'd0;
			cfg_q.absolute_mode    <= 1'b0;
			cfg_q.step_size        <= 7'd1;
			cfg_q.max_value        <= 7'd127;
			cfg_q.encoder_count    <= 5'd16;
			cfg_q.controllers_low  <= '0;
			cfg_q.controllers_high <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIDI_CHANNEL:     cfg_q.midi_channel     <= cfg_data[3:0];
				CFG_ABSOLUTE_MODE:    cfg_q.absolute_mode    <= cfg_data[0];
				CFG_STEP_SIZE:        cfg_q.step_size        <= cfg_data[6:0];
				CFG_MAX_VALUE:        cfg_q.max_value        <= cfg_data[6:0];
				CFG_ENCODER_COUNT:    cfg_q.encoder_count    <= cfg_data[4:0];
				CFG_CONTROLLERS_LOW:  cfg_q.controllers_low  <= cfg_data;
				CFG_CONTROLLERS_HIGH: cfg_q.controllers_high <= cfg_data;
				default: ;
			endcase
		end
	end

	// scan acceptance
	assign in_ready     = !busy;
	assign accept       = in_valid && in_ready;
	assign ctl.group_ok = (int'(in_word.group_sel) < GROUPS);
	assign ctl.load     = accept && ctl.group_ok;
	assign ctl.prime    = in_word.prime;
	assign ctl.group_sel = in_word.group_sel;

	// decode lanes
	for (genvar n = 0; n < EPG; n++) begin : g_lane
		logic                 en;
		logic [ENC_IDX_W-1:0] enc;

		assign enc = ENC_IDX_W'(in_word.group_sel) * ENC_IDX_W'(EPG) + ENC_IDX_W'(n);
		assign en  = enc < ENC_IDX_W'(cfg_q.encoder_count);

		qenc_lane #(
			.GROUPS (GROUPS)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.cfg     (cfg_q),
			.a       (in_word.a_bits[n]),
			.b       (in_word.b_bits[n]),
			.en      (en),
			.evt     (evt[n]),
			.data_s1 (lane_data[n])
		);
	end

	// ordering and output
	qenc_merge #(
		.ENCODERS_PER_GROUP (EPG)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (ctl.load),
		.evt       (evt),
		.group_sel (in_word.group_sel),
		.data      (lane_data),
		.cfg       (cfg_q),
		.busy      (busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	// a priming scan leaves nothing to send
	a_prime_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_word.prime |=> in_ready)
		else $error("prime scan left words pending");

	// a word that is not the last means more are queued behind it
	a_not_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.last |-> !in_ready)
		else $error("scan accepted before all words sent");

	// priming on an empty output produces no word
	a_prime_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_word.prime && !out_valid |=> !out_valid)
		else $error("prime scan produced a word");

endmodule

@@ src/qenc_lane.sv @@
// ----------------------------------------------------------------------------
// qenc_lane
// One encoder slot of a group: previous phases and position per group,
// transition decode and the event value for the current scan.
// ----------------------------------------------------------------------------
module qenc_lane import qenc_pkg::*; #(
	parameter int GROUPS = GROUPS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  lane_ctl_t  ctl,
	input  cfg_t       cfg,
	input  logic       a,
	input  logic       b,
	input  logic       en,
	output logic       evt,
	output logic [6:0] data_s1
);

	localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

	logic       prev_a_q [GROUPS];
	logic       prev_b_q [GROUPS];
	logic [6:0] pos_q    [GROUPS];

	logic [GW-1:0] gi;
	logic          a_m, b_m;
	move_t         mv;
	logic [6:0]    pos, up_p, dn_raw, dn_p, new_p, val;
	logic [7:0]    sum;

	assign gi  = GW'(ctl.group_sel);
	assign a_m = a & en;
	assign b_m = b & en;

	// decode and position update
	always_comb begin
		pos    = pos_q[gi];
		mv     = move_of({prev_b_q[gi], prev_a_q[gi], b_m, a_m});
		sum    = {1'b0, pos} + {1'b0, cfg.step_size};
		up_p   = (sum > {1'b0, cfg.max_value}) ? cfg.max_value : sum[6:0];
		dn_raw = (pos < cfg.step_size) ? 7'd0 : pos - cfg.step_size;
		dn_p   = (dn_raw > cfg.max_value) ? cfg.max_value : dn_raw;
		new_p  = (mv == MOVE_UP) ? up_p : dn_p;
		if (cfg.absolute_mode) begin
			val = new_p;
		end else begin
			val = (mv == MOVE_UP) ? DATA_UP : DATA_DOWN;
		end
	end

	assign evt = ctl.group_ok && !ctl.prime && (mv != MOVE_NONE);

	// per-group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < GROUPS; g++) begin
				prev_a_q[g] <= 1'b0;
				prev_b_q[g] <= 1'b0;
				pos_q[g]    <= '0;
			end
		end else if (ctl.load) begin
			prev_a_q[gi] <= a_m;
			prev_b_q[gi] <= b_m;
			if (evt && cfg.absolute_mode) begin
				pos_q[gi] <= new_p;
			end
		end
	end

	// event value held for the merge stage
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_s1 <= val;
		end
	end

endmodule

@@ src/qenc_merge.sv @@
// ----------------------------------------------------------------------------
// qenc_merge
// Collects the lane events of one scan and sends them out one word per
// cycle while the output is not stalled, in encoder order, marking the last.
// ----------------------------------------------------------------------------
module qenc_merge import qenc_pkg::*; #(
	parameter int ENCODERS_PER_GROUP = ENCODERS_PER_GROUP_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [ENCODERS_PER_GROUP-1:0] evt,
	input  logic                          group_sel,
	input  logic [6:0]                    data [ENCODERS_PER_GROUP],
	input  cfg_t                          cfg,
	output logic                          busy,
	output logic                          out_valid,
	input  logic                          out_ready,
	output out_word_t                     out_word
);

	localparam int EPG = ENCODERS_PER_GROUP;
	localparam int LW  = (EPG > 1) ? $clog2(EPG) : 1;

	logic [EPG-1:0]       pend_q, grant, rest;
	logic                 group_q;
	logic [LW-1:0]        idx;
	logic [ENC_IDX_W-1:0] enc;
	logic [127:0]         ctrls;
	logic [7:0]           ctrl;
	logic                 emit;

	// lowest pending lane
	always_comb begin
		idx = '0;
		for (int n = EPG - 1; n >= 0; n--) begin
			if (pend_q[n]) begin
				idx = LW'(n);
			end
		end
	end

	assign grant = pend_q & (~pend_q + EPG'(1));
	assign rest  = pend_q & ~grant;
	assign busy  = (pend_q != '0);
	assign emit  = busy && (!out_valid || out_ready);

	// controller lookup by global encoder number
	assign enc   = ENC_IDX_W'(group_q) * ENC_IDX_W'(EPG) + ENC_IDX_W'(idx);
	assign ctrls = {cfg.controllers_high, cfg.controllers_low};
	assign ctrl  = (enc < ENC_IDX_W'(16)) ? ctrls[{enc[3:0], 3'b000} +: 8] : 8'd0;

	// pending mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= evt;
		end else if (emit) begin
			pend_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			group_q <= group_sel;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_word.usb_header  <= USB_HDR_CC;
			out_word.status_byte <= STATUS_CC | {4'h0, cfg.midi_channel};
			out_word.controller  <= ctrl;
			out_word.data_value  <= data[idx];
			out_word.last        <= (rest == '0);
		end
	end

endmodule

@@ verif/quadrature_encoders_to_midi_cc_tb.sv @@
// ----------------------------------------------------------------------------
// quadrature_encoders_to_midi_cc_tb
// Drives encoder scans into the MIDI control-change block and checks every
// output word against a cycle-free model of phase decode, position tracking
// and event ordering. Directed scans cover full-group moves, priming, invalid
// transitions, clamping and encoder masking; random phases mix legal Gray
// steps with noise under changing register settings, bursty input and a
// stalling receiver.
// ----------------------------------------------------------------------------
module quadrature_encoders_to_midi_cc_tb import qenc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int EPG = ENCODERS_PER_GROUP_DEF;
	localparam int GRP = GROUPS_DEF;

	// expected control-change words and the model state behind them
	class midi_cc_tracker;
		cfg_t        regs;
		logic [7:0]  prev_a[GRP];
		logic [7:0]  prev_b[GRP];
		logic [6:0]  position[GRP*EPG];
		out_word_t   pending_cc_words[$];
		int          errors;

		function new();
			regs.midi_channel     = '0;
			regs.absolute_mode    = 1'b0;
			regs.step_size        = 7'd1;
			regs.max_value        = 7'd127;
			regs.encoder_count    = 5'd16;
			regs.controllers_low  = '0;
			regs.controllers_high = '0;
			foreach (prev_a[g]) begin
				prev_a[g] = '0;
				prev_b[g] = '0;
			end
			foreach (position[e])
				position[e] = '0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			errors++;
		endtask

		function int pending();
			return pending_cc_words.size();
		endfunction

		function void set_reg(cfg_reg_t idx, logic [63:0] v);
			case (idx)
				CFG_MIDI_CHANNEL:     regs.midi_channel     = v[3:0];
				CFG_ABSOLUTE_MODE:    regs.absolute_mode    = v[0];
				CFG_STEP_SIZE:        regs.step_size        = v[6:0];
				CFG_MAX_VALUE:        regs.max_value        = v[6:0];
				CFG_ENCODER_COUNT:    regs.encoder_count    = v[4:0];
				CFG_CONTROLLERS_LOW:  regs.controllers_low  = v;
				CFG_CONTROLLERS_HIGH: regs.controllers_high = v;
				default: ;
			endcase
		endfunction

		// {prev B, prev A, new B, new A} -> direction
		function move_t step_dir(logic [3:0] code);
			case (code)
				4'b0010, 4'b1101: return MOVE_UP;
				4'b0111, 4'b1000: return MOVE_DOWN;
				default:          return MOVE_NONE;
			endcase
		endfunction

		function void note_scan(in_word_t w);
			logic [7:0]  en, a, b, pa, pb;
			int unsigned g, lim, enc, p;
			move_t       mv;
			out_word_t   ow, held;
			bit          have_held;
			g = 32'(w.group_sel);
			lim = (regs.encoder_count > GRP*EPG) ? GRP*EPG : 32'(regs.encoder_count);
			en = '0;
			for (int n = 0; n < EPG; n++)
				if (g*EPG + n < lim)
					en[n] = 1'b1;
			a = w.a_bits & en;
			b = w.b_bits & en;
			pa = prev_a[g];
			pb = prev_b[g];
			prev_a[g] = a;
			prev_b[g] = b;
			if (w.prime)
				return;
			have_held = 1'b0;
			for (int n = 0; n < EPG; n++) begin
				mv = step_dir({pb[n], pa[n], b[n], a[n]});
				if (mv == MOVE_NONE)
					continue;
				enc = g*EPG + n;
				ow.usb_header  = USB_HDR_CC;
				ow.status_byte = STATUS_CC | {4'h0, regs.midi_channel};
				if (enc < 8)
					ow.controller = regs.controllers_low[8*enc +: 8];
				else
					ow.controller = regs.controllers_high[8*(enc-8) +: 8];
				if (regs.absolute_mode) begin
					p = 32'(position[enc]);
					if (mv == MOVE_UP)
						p = p + 32'(regs.step_size);
					else
						p = (p < regs.step_size) ? 0 : p - 32'(regs.step_size);
					if (p > regs.max_value)
						p = 32'(regs.max_value);
					position[enc] = p[6:0];
					ow.data_value = p[6:0];
				end else begin
					ow.data_value = (mv == MOVE_UP) ? DATA_UP : DATA_DOWN;
				end
				ow.last = 1'b0;
				// hold one back so the final word of the scan can be marked
				if (have_held)
					pending_cc_words.push_back(held);
				held = ow;
				have_held = 1'b1;
			end
			if (have_held) begin
				held.last = 1'b1;
				pending_cc_words.push_back(held);
			end
		endfunction

		task check_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("%s got %02h want %02h", name, got, want));
		endtask

		task check_word(out_word_t w);
			out_word_t want;
			if (pending_cc_words.size() == 0) begin
				report($sformatf("unexpected word %h", w));
				return;
			end
			want = pending_cc_words.pop_front();
			check_field("usb_header", w.usb_header, want.usb_header);
			check_field("status_byte", w.status_byte, want.status_byte);
			check_field("controller", w.controller, want.controller);
			check_field("data_value", {1'b0, w.data_value}, {1'b0, want.data_value});
			check_field("last", {7'h0, w.last}, {7'h0, want.last});
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_word_t              in_word = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_word;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	midi_cc_tracker tracker = new;
	int burst_left = 0;
	int rx_mode = 0;
	int rx_mode_left = 0;
	int rx_hold = 0;
	logic [7:0] gen_a[GRP];
	logic [7:0] gen_b[GRP];

	quadrature_encoders_to_midi_cc DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// receiver: always ready, coin flip, or occasional long stalls
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_mode_left = $urandom_range(40, 200);
		end else begin
			rx_mode_left--;
		end
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			default: begin
				if (rx_hold > 0) begin
					rx_hold--;
					out_ready <= 1'b0;
				end else if ($urandom_range(0, 7) == 0) begin
					rx_hold = $urandom_range(1, 12);
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		endcase
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_word(out_word);
	end

	// one scan word, sent in bursts with random gaps between them
	task automatic send_item(in_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		tracker.note_scan(w);
	endtask

	task automatic scan_bits(bit g, logic [7:0] a, logic [7:0] b, bit p);
		in_word_t w;
		w.group_sel = g;
		w.a_bits = a;
		w.b_bits = b;
		w.prime = p;
		send_item(w);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.set_reg(idx, val);
	endtask

	// stop sending, let all words out, then give the block time to go idle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	initial begin
		in_word_t    w;
		int          r, g, mv, idx;
		logic [63:0] v;

		foreach (gen_a[i]) begin
			gen_a[i] = '0;
			gen_b[i] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// directed: relative mode, all encoders on
		write_reg(CFG_MIDI_CHANNEL, 64'd15);
		write_reg(CFG_ABSOLUTE_MODE, 64'd0);
		write_reg(CFG_STEP_SIZE, 64'd1);
		write_reg(CFG_MAX_VALUE, 64'd127);
		write_reg(CFG_ENCODER_COUNT, 64'd16);
		write_reg(CFG_CONTROLLERS_LOW, 64'h00112233445566FF);
		write_reg(CFG_CONTROLLERS_HIGH, 64'h807FA55AC33C0FF0);
		scan_bits(0, 8'h00, 8'h00, 1);
		scan_bits(0, 8'h00, 8'hFF, 0);   // every encoder up
		scan_bits(0, 8'h00, 8'h00, 0);   // every encoder down
		scan_bits(0, 8'hFF, 8'hFF, 0);   // both phases flipped, nothing
		scan_bits(0, 8'hFF, 8'h00, 0);
		scan_bits(0, 8'hFF, 8'hFF, 0);
		scan_bits(1, 8'hFF, 8'hFF, 1);
		scan_bits(1, 8'h00, 8'h00, 0);
		scan_bits(1, 8'h00, 8'hAA, 0);
		scan_bits(1, 8'h55, 8'hFF, 0);
		drain();

		// absolute mode, clamping at both ends
		write_reg(CFG_MIDI_CHANNEL, 64'd0);
		write_reg(CFG_ABSOLUTE_MODE, 64'd1);
		write_reg(CFG_STEP_SIZE, 64'd127);
		scan_bits(0, 8'h00, 8'h00, 1);
		scan_bits(0, 8'h00, 8'hFF, 0);
		scan_bits(0, 8'h00, 8'h00, 0);
		scan_bits(0, 8'h00, 8'hFF, 0);
		drain();

		// zero step still emits, then a ceiling of zero
		write_reg(CFG_STEP_SIZE, 64'd0);
		scan_bits(0, 8'h00, 8'h00, 0);
		drain();
		write_reg(CFG_STEP_SIZE, 64'd3);
		write_reg(CFG_MAX_VALUE, 64'd0);
		scan_bits(0, 8'h00, 8'hFF, 0);
		scan_bits(0, 8'h00, 8'h00, 0);
		drain();

		// encoder masking
		write_reg(CFG_ENCODER_COUNT, 64'd1);
		scan_bits(0, 8'h00, 8'hFF, 0);
		scan_bits(1, 8'h00, 8'hFF, 0);
		drain();
		write_reg(CFG_ENCODER_COUNT, 64'd0);
		scan_bits(0, 8'h00, 8'h00, 0);
		drain();
		write_reg(CFG_ENCODER_COUNT, 64'd31);
		write_reg(CFG_STEP_SIZE, 64'd5);
		write_reg(CFG_MAX_VALUE, 64'd100);
		scan_bits(1, 8'h00, 8'h00, 1);
		scan_bits(1, 8'h00, 8'hFF, 0);
		scan_bits(0, 8'h00, 8'hFF, 0);
		drain();
		write_reg(CFG_ENCODER_COUNT, 64'd9);
		scan_bits(1, 8'h00, 8'h00, 0);
		drain();

		// random phases
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_MIDI_CHANNEL, 64'($urandom_range(0, 15)));
			write_reg(CFG_ABSOLUTE_MODE, 64'(ph % 2));
			r = $urandom_range(0, 9);
			v = (r == 0) ? 64'd1 : (r == 1) ? 64'd127 : (r == 2) ? 64'd0
				: 64'($urandom_range(1, 127));
			write_reg(CFG_STEP_SIZE, v);
			r = $urandom_range(0, 9);
			v = (r == 0) ? 64'd0 : (r == 1) ? 64'd127 : 64'($urandom_range(0, 127));
			write_reg(CFG_MAX_VALUE, v);
			r = $urandom_range(0, 9);
			v = (r == 0) ? 64'd1 : (r == 1) ? 64'd16 : (r == 2) ? 64'd31 : (r == 3) ? 64'd0
				: 64'($urandom_range(1, 16));
			write_reg(CFG_ENCODER_COUNT, v);
			write_reg(CFG_CONTROLLERS_LOW, {$urandom, $urandom});
			write_reg(CFG_CONTROLLERS_HIGH, {$urandom, $urandom});
			for (int k = 0; k < 60; k++) begin
				r = $urandom_range(0, 99);
				g = $urandom_range(0, GRP - 1);
				w.group_sel = g[0];
				w.prime = 1'b0;
				if (r < 20) begin
					// noise, sometimes as a prime
					w.prime = (r < 6);
					w.a_bits = 8'($urandom);
					w.b_bits = 8'($urandom);
				end else begin
					// each encoder holds or takes one Gray step either way
					for (int n = 0; n < EPG; n++) begin
						case ({gen_b[g][n], gen_a[g][n]})
							2'b00:   idx = 0;
							2'b10:   idx = 1;
							2'b11:   idx = 2;
							default: idx = 3;
						endcase
						mv = $urandom_range(0, 3);
						if (mv == 1)
							idx = (idx + 1) % 4;
						else if (mv == 2)
							idx = (idx + 3) % 4;
						w.b_bits[n] = (idx == 1 || idx == 2);
						w.a_bits[n] = (idx == 2 || idx == 3);
					end
				end
				gen_a[g] = w.a_bits;
				gen_b[g] = w.b_bits;
				send_item(w);
			end
			drain();
		end

		repeat (40) @(posedge clk);
		if (tracker.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
